>>> hdl/rrc_pkg.sv
// ----------------------------------------------------------------------------
// Register renamer package
// Shared types and constants of the renamer and its storage.
// ----------------------------------------------------------------------------
`default_nettype none

package rrc_pkg;

   localparam int LOG_REGS   = 64;
   localparam int FREE_SLOTS = 64;
   localparam int BRANCHES   = 16;

   localparam int LW = 6;   // logical register index
   localparam int PW = 7;   // physical register index
   localparam int SW = 6;   // free list / active list slot
   localparam int BW = 4;   // branch id
   localparam int IW = 24;  // active list info word

   localparam logic [3:0] ACT_SRC      = 4'd0;
   localparam logic [3:0] ACT_DST      = 4'd1;
   localparam logic [3:0] ACT_CKPT     = 4'd2;
   localparam logic [3:0] ACT_DISPATCH = 4'd3;
   localparam logic [3:0] ACT_SET_DONE = 4'd4;
   localparam logic [3:0] ACT_SET_VMIS = 4'd8;
   localparam logic [3:0] ACT_RESOLVE  = 4'd9;
   localparam logic [3:0] ACT_HEAD     = 4'd10;
   localparam logic [3:0] ACT_COMMIT   = 4'd11;
   localparam logic [3:0] ACT_SQUASH   = 4'd12;

   localparam logic [2:0] ERR_OK        = 3'd0;
   localparam logic [2:0] ERR_FREE_EMPTY = 3'd1;
   localparam logic [2:0] ERR_AL_FULL   = 3'd2;
   localparam logic [2:0] ERR_NO_BRANCH = 3'd3;
   localparam logic [2:0] ERR_NO_COMMIT = 3'd4;

   localparam logic [6:0] SLOTS_FULL = 7'd64;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_ARCH,
      ST_SWEEP,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

>>> hdl/rrc_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port; the read word is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module rrc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end

endmodule

`default_nettype wire

>>> hdl/register_renamer_with_checkpoints.sv
// ----------------------------------------------------------------------------
// Register renamer with branch checkpoints
// Rename map, architectural map, circular free list, active list and branch
// checkpoints, driven one action word at a time.
// ----------------------------------------------------------------------------
// Use: one action word in on the req_ channel gives exactly one result word
// on the rsp_ channel. Both channels use valid/ready.
// After reset the INIT step writes the identity maps and the initial free list;
// req_ready stays low meanwhile.
// Sequencer steps after acceptance, each run in order up to FINISH:
//   EXEC: dispatch, unused codes, correct or unheld resolve, and refusals
//   or head reads decided from the counters alone;
//   EXEC, READ: source, destination, flag set, head read, other commits;
//   EXEC, READ, ARCH: a commit with a destination that goes ahead (two RAM reads);
//   EXEC, SWEEP: checkpoint, mispredict and squash, a 64-entry map
//   copy through one RAM read port.
// req_ready is high only in the idle step, so no new word is taken before the
// last result is in the output register, which lets the next word in while
// a result waits; a stalled receiver holds the sequencer at its last step.
// ----------------------------------------------------------------------------
`default_nettype none

module register_renamer_with_checkpoints (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [3:0]  req_action,
   input  wire logic [5:0]  req_log_reg,
   input  wire logic [6:0]  req_dest_preg,
   input  wire logic        req_has_dest,
   input  wire logic [4:0]  req_kind_bits,
   input  wire logic [63:0] req_pc,
   input  wire logic [5:0]  req_alist_slot,
   input  wire logic [3:0]  req_br_tag,
   input  wire logic        req_correct,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [6:0]       rsp_phys_out,
   output logic [3:0]       rsp_br_tag_out,
   output logic [5:0]       rsp_alist_slot_out,
   output logic             rsp_head_valid,
   output logic [9:0]       rsp_head_flags,
   output logic [63:0]      rsp_head_pc,
   output logic [6:0]       rsp_free_count,
   output logic [6:0]       rsp_active_count,
   output logic [15:0]      rsp_branch_mask,
   output logic [2:0]       rsp_error
);
   import rrc_pkg::*;

   state_type state_ff, state_in;
   logic [6:0]  cnt_ff, cnt_in;

   logic [3:0]  act_ff, act_in;
   logic [LW-1:0] lreg_ff, lreg_in;
   logic [PW-1:0] preg_ff, preg_in;
   logic        dvalid_ff, dvalid_in;
   logic [4:0]  kind_ff, kind_in;
   logic [63:0] pc_ff, pc_in;
   logic [SW-1:0] alx_ff, alx_in;
   logic [BW-1:0] bid_ff, bid_in;
   logic        corr_ff, corr_in;

   logic [SW-1:0] free_head_ff, free_head_in, free_tail_ff, free_tail_in;
   logic [6:0]    free_used_ff, free_used_in;
   logic [SW-1:0] al_head_ff, al_head_in, al_tail_ff, al_tail_in;
   logic [6:0]    al_used_ff, al_used_in;
   logic [BRANCHES-1:0] gmask_ff, gmask_in;
   logic [BRANCHES-1:0] ckmask_ff [BRANCHES];
   logic [BRANCHES-1:0] ckmask_in [BRANCHES];
   logic [SW-1:0]       ckhead_ff [BRANCHES];
   logic [SW-1:0]       ckhead_in [BRANCHES];

   logic [PW-1:0] res_phys_ff, res_phys_in;
   logic [BW-1:0] res_bid_ff, res_bid_in;
   logic [SW-1:0] res_alx_ff, res_alx_in;
   logic          res_hv_ff, res_hv_in;
   logic [9:0]    res_flags_ff, res_flags_in;
   logic [63:0]   res_pc_ff, res_pc_in;
   logic [2:0]    res_err_ff, res_err_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [PW-1:0] rsp_phys_ff, rsp_phys_in;
   logic [BW-1:0] rsp_bid_ff, rsp_bid_in;
   logic [SW-1:0] rsp_alx_ff, rsp_alx_in;
   logic          rsp_hv_ff, rsp_hv_in;
   logic [9:0]    rsp_flags_ff, rsp_flags_in;
   logic [63:0]   rsp_pc_ff, rsp_pc_in;
   logic [6:0]    rsp_free_ff, rsp_free_in;
   logic [6:0]    rsp_used_ff, rsp_used_in;
   logic [15:0]   rsp_mask_ff, rsp_mask_in;
   logic [2:0]    rsp_err_ff, rsp_err_in;

   // RAM ports
   logic          ren_we, ren_re, arch_we, arch_re, frl_we, frl_re;
   logic          info_we, info_re, apc_we, apc_re, ckm_we, ckm_re;
   logic [LW-1:0] ren_wa, ren_ra, arch_wa, arch_ra;
   logic [SW-1:0] frl_wa, frl_ra, info_wa, info_ra, apc_wa, apc_ra;
   logic [BW+LW-1:0] ckm_wa, ckm_ra;
   logic [PW-1:0] ren_wd, ren_rd, arch_wd, arch_rd, frl_wd, frl_rd, ckm_wd, ckm_rd;
   logic [IW-1:0] info_wd, info_rd;
   logic [63:0]   apc_wd, apc_rd;

   logic          accept, out_free, sweep_last, found_any, commit_ok;
   logic [BW-1:0] found;
   logic [LW-1:0] sweep_wa;
   logic [7:0]    restore_sum;

   rrc_ram #(.WIDTH(PW), .DEPTH(LOG_REGS)) u_rename (
      .clock(clock), .we(ren_we), .waddr(ren_wa), .wdata(ren_wd),
      .re(ren_re), .raddr(ren_ra), .rdata(ren_rd));
   rrc_ram #(.WIDTH(PW), .DEPTH(LOG_REGS)) u_arch (
      .clock(clock), .we(arch_we), .waddr(arch_wa), .wdata(arch_wd),
      .re(arch_re), .raddr(arch_ra), .rdata(arch_rd));
   rrc_ram #(.WIDTH(PW), .DEPTH(FREE_SLOTS)) u_free (
      .clock(clock), .we(frl_we), .waddr(frl_wa), .wdata(frl_wd),
      .re(frl_re), .raddr(frl_ra), .rdata(frl_rd));
   rrc_ram #(.WIDTH(IW), .DEPTH(FREE_SLOTS)) u_info (
      .clock(clock), .we(info_we), .waddr(info_wa), .wdata(info_wd),
      .re(info_re), .raddr(info_ra), .rdata(info_rd));
   rrc_ram #(.WIDTH(64), .DEPTH(FREE_SLOTS)) u_apc (
      .clock(clock), .we(apc_we), .waddr(apc_wa), .wdata(apc_wd),
      .re(apc_re), .raddr(apc_ra), .rdata(apc_rd));
   rrc_ram #(.WIDTH(PW), .DEPTH(BRANCHES*LOG_REGS)) u_ckpt (
      .clock(clock), .we(ckm_we), .waddr(ckm_wa), .wdata(ckm_wd),
      .re(ckm_re), .raddr(ckm_ra), .rdata(ckm_rd));

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign sweep_last = (cnt_ff == 7'd64);
   assign sweep_wa  = cnt_ff[LW-1:0] - 1'b1;
   assign commit_ok = info_rd[0] && !info_rd[1] && !info_rd[2];
   assign restore_sum = {1'b0, free_used_ff}
                      + {2'b0, free_head_ff - ckhead_ff[bid_ff]};

   // Highest clear bit of the global mask.
   always_comb begin
      found     = '0;
      found_any = 1'b0;
      for (int b = 0; b < BRANCHES; b++) begin
         if (!gmask_ff[b]) begin
            found     = BW'(b);
            found_any = 1'b1;
         end
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (cnt_ff[LW-1:0] == LW'(LOG_REGS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_FINISH;
            case (act_ff)
               ACT_SRC: state_in = ST_READ;
               ACT_DST: if (free_used_ff != 7'd0) state_in = ST_READ;
               ACT_CKPT: if (found_any) state_in = ST_SWEEP;
               ACT_RESOLVE: if (gmask_ff[bid_ff] && !corr_ff) state_in = ST_SWEEP;
               ACT_HEAD, ACT_COMMIT: if (al_used_ff != 7'd0) state_in = ST_READ;
               ACT_SQUASH: state_in = ST_SWEEP;
               default: begin
                  if (act_ff inside {[ACT_SET_DONE:ACT_SET_VMIS]}) state_in = ST_READ;
               end
            endcase
         end
         ST_READ: begin
            if (act_ff == ACT_COMMIT && commit_ok && info_rd[10]) state_in = ST_ARCH;
            else state_in = ST_FINISH;
         end
         ST_ARCH:  state_in = ST_FINISH;
         ST_SWEEP: if (sweep_last) state_in = ST_FINISH;
         ST_FINISH: if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_INIT;
      endcase
   end

   // Datapath and RAM controls.
   always_comb begin
      cnt_in = cnt_ff;
      act_in = act_ff; lreg_in = lreg_ff; preg_in = preg_ff; dvalid_in = dvalid_ff;
      kind_in = kind_ff; pc_in = pc_ff; alx_in = alx_ff; bid_in = bid_ff;
      corr_in = corr_ff;
      free_head_in = free_head_ff; free_tail_in = free_tail_ff;
      free_used_in = free_used_ff;
      al_head_in = al_head_ff; al_tail_in = al_tail_ff; al_used_in = al_used_ff;
      gmask_in = gmask_ff;
      for (int i = 0; i < BRANCHES; i++) begin
         ckmask_in[i] = ckmask_ff[i];
         ckhead_in[i] = ckhead_ff[i];
      end
      res_phys_in = res_phys_ff; res_bid_in = res_bid_ff; res_alx_in = res_alx_ff;
      res_hv_in = res_hv_ff; res_flags_in = res_flags_ff; res_pc_in = res_pc_ff;
      res_err_in = res_err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_phys_in = rsp_phys_ff; rsp_bid_in = rsp_bid_ff; rsp_alx_in = rsp_alx_ff;
      rsp_hv_in = rsp_hv_ff; rsp_flags_in = rsp_flags_ff; rsp_pc_in = rsp_pc_ff;
      rsp_free_in = rsp_free_ff; rsp_used_in = rsp_used_ff;
      rsp_mask_in = rsp_mask_ff; rsp_err_in = rsp_err_ff;

      ren_we = 1'b0; ren_re = 1'b0; ren_wa = '0; ren_ra = '0; ren_wd = '0;
      arch_we = 1'b0; arch_re = 1'b0; arch_wa = '0; arch_ra = '0; arch_wd = '0;
      frl_we = 1'b0; frl_re = 1'b0; frl_wa = '0; frl_ra = '0; frl_wd = '0;
      info_we = 1'b0; info_re = 1'b0; info_wa = '0; info_ra = '0; info_wd = '0;
      apc_we = 1'b0; apc_re = 1'b0; apc_wa = '0; apc_ra = '0; apc_wd = '0;
      ckm_we = 1'b0; ckm_re = 1'b0; ckm_wa = '0; ckm_ra = '0; ckm_wd = '0;

      case (state_ff)
         ST_INIT: begin
            ren_we  = 1'b1; ren_wa  = cnt_ff[LW-1:0]; ren_wd  = PW'(cnt_ff[LW-1:0]);
            arch_we = 1'b1; arch_wa = cnt_ff[LW-1:0]; arch_wd = PW'(cnt_ff[LW-1:0]);
            frl_we  = 1'b1; frl_wa  = cnt_ff[SW-1:0];
            frl_wd  = PW'(LOG_REGS) + PW'(cnt_ff[SW-1:0]);
            cnt_in  = cnt_ff + 7'd1;
         end
         ST_IDLE: begin
            if (accept) begin
               act_in = req_action; lreg_in = req_log_reg; preg_in = req_dest_preg;
               dvalid_in = req_has_dest; kind_in = req_kind_bits; pc_in = req_pc;
               alx_in = req_alist_slot; bid_in = req_br_tag; corr_in = req_correct;
               res_phys_in = '0; res_bid_in = '0; res_alx_in = '0; res_hv_in = 1'b0;
               res_flags_in = '0; res_pc_in = '0; res_err_in = ERR_OK;
               cnt_in = '0;
            end
         end
         ST_EXEC: begin
            case (act_ff)
               ACT_SRC: begin
                  ren_re = 1'b1; ren_ra = lreg_ff;
               end
               ACT_DST: begin
                  if (free_used_ff == 7'd0) res_err_in = ERR_FREE_EMPTY;
                  else begin
                     frl_re = 1'b1; frl_ra = free_head_ff;
                  end
               end
               ACT_CKPT: begin
                  if (!found_any) res_err_in = ERR_NO_BRANCH;
                  else begin
                     ckmask_in[found] = gmask_ff;
                     ckhead_in[found] = free_head_ff;
                     gmask_in[found]  = 1'b1;
                     bid_in     = found;
                     res_bid_in = found;
                  end
               end
               ACT_DISPATCH: begin
                  if (al_used_ff >= SLOTS_FULL) res_err_in = ERR_AL_FULL;
                  else begin
                     info_we = 1'b1; info_wa = al_tail_ff;
                     info_wd = {preg_ff, lreg_ff, dvalid_ff, kind_ff, 5'b0};
                     apc_we  = 1'b1; apc_wa = al_tail_ff; apc_wd = pc_ff;
                     res_alx_in = al_tail_ff;
                     al_tail_in = al_tail_ff + 1'b1;
                     al_used_in = al_used_ff + 7'd1;
                  end
               end
               ACT_RESOLVE: begin
                  if (gmask_ff[bid_ff]) begin
                     if (corr_ff) begin
                        gmask_in[bid_ff] = 1'b0;
                        for (int i = 0; i < BRANCHES; i++) begin
                           ckmask_in[i][bid_ff] = 1'b0;
                        end
                     end else begin
                        gmask_in     = ckmask_ff[bid_ff];
                        free_head_in = ckhead_ff[bid_ff];
                        free_used_in = (restore_sum > 8'(SLOTS_FULL)) ? SLOTS_FULL
                                                                      : restore_sum[6:0];
                        al_tail_in   = alx_ff + 1'b1;
                        // An empty distance means the list wrapped round to full.
                        al_used_in   = (alx_ff + 1'b1 == al_head_ff) ? SLOTS_FULL
                                     : 7'(SW'(alx_ff + 1'b1 - al_head_ff));
                     end
                  end
               end
               ACT_HEAD: begin
                  info_re = 1'b1; info_ra = al_head_ff;
                  apc_re  = 1'b1; apc_ra  = al_head_ff;
               end
               ACT_COMMIT: begin
                  if (al_used_ff == 7'd0) res_err_in = ERR_NO_COMMIT;
                  else begin
                     info_re = 1'b1; info_ra = al_head_ff;
                  end
               end
               ACT_SQUASH: begin
                  al_tail_in   = al_head_ff;
                  al_used_in   = '0;
                  free_head_in = free_tail_ff;
                  free_used_in = SLOTS_FULL;
                  gmask_in     = '0;
                  for (int i = 0; i < BRANCHES; i++) begin
                     ckmask_in[i] = '0;
                     ckhead_in[i] = '0;
                  end
               end
               default: begin
                  if (act_ff inside {[ACT_SET_DONE:ACT_SET_VMIS]}) begin
                     info_re = 1'b1; info_ra = alx_ff;
                  end
               end
            endcase
         end
         ST_READ: begin
            case (act_ff)
               ACT_SRC: res_phys_in = ren_rd;
               ACT_DST: begin
                  res_phys_in  = frl_rd;
                  ren_we = 1'b1; ren_wa = lreg_ff; ren_wd = frl_rd;
                  free_head_in = free_head_ff + 1'b1;
                  free_used_in = free_used_ff - 7'd1;
               end
               ACT_HEAD: begin
                  res_hv_in    = 1'b1;
                  res_flags_in = info_rd[9:0];
                  res_pc_in    = apc_rd;
               end
               ACT_COMMIT: begin
                  if (!commit_ok) res_err_in = ERR_NO_COMMIT;
                  else if (info_rd[10]) begin
                     arch_re = 1'b1; arch_ra = info_rd[16:11];
                  end else begin
                     al_head_in = al_head_ff + 1'b1;
                     al_used_in = al_used_ff - 7'd1;
                  end
               end
               default: begin
                  info_we = 1'b1; info_wa = alx_ff;
                  info_wd = info_rd | (IW'(1) << (act_ff - ACT_SET_DONE));
               end
            endcase
         end
         ST_ARCH: begin
            arch_we = 1'b1; arch_wa = info_rd[16:11]; arch_wd = info_rd[23:17];
            if (free_used_ff < SLOTS_FULL) begin
               frl_we = 1'b1; frl_wa = free_tail_ff; frl_wd = arch_rd;
               free_tail_in = free_tail_ff + 1'b1;
               free_used_in = free_used_ff + 7'd1;
            end
            al_head_in = al_head_ff + 1'b1;
            al_used_in = al_used_ff - 7'd1;
         end
         ST_SWEEP: begin
            // Read entry cnt while writing entry cnt-1, whose word the last read returned.
            cnt_in = cnt_ff + 7'd1;
            case (act_ff)
               ACT_CKPT: begin
                  ren_re = 1'b1; ren_ra = cnt_ff[LW-1:0];
                  ckm_we = (cnt_ff != 7'd0); ckm_wa = {bid_ff, sweep_wa}; ckm_wd = ren_rd;
               end
               ACT_RESOLVE: begin
                  ckm_re = 1'b1; ckm_ra = {bid_ff, cnt_ff[LW-1:0]};
                  ren_we = (cnt_ff != 7'd0); ren_wa = sweep_wa; ren_wd = ckm_rd;
               end
               default: begin
                  arch_re = 1'b1; arch_ra = cnt_ff[LW-1:0];
                  ren_we = (cnt_ff != 7'd0); ren_wa = sweep_wa; ren_wd = arch_rd;
               end
            endcase
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_phys_in = res_phys_ff; rsp_bid_in = res_bid_ff;
               rsp_alx_in = res_alx_ff; rsp_hv_in = res_hv_ff;
               rsp_flags_in = res_flags_ff; rsp_pc_in = res_pc_ff;
               rsp_free_in = free_used_ff; rsp_used_in = al_used_ff;
               rsp_mask_in = gmask_ff; rsp_err_in = res_err_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         cnt_ff       <= '0;
         free_head_ff <= '0;
         free_tail_ff <= '0;
         free_used_ff <= SLOTS_FULL;
         al_head_ff   <= '0;
         al_tail_ff   <= '0;
         al_used_ff   <= '0;
         gmask_ff     <= '0;
         for (int i = 0; i < BRANCHES; i++) begin
            ckmask_ff[i] <= '0;
            ckhead_ff[i] <= '0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         free_head_ff <= free_head_in;
         free_tail_ff <= free_tail_in;
         free_used_ff <= free_used_in;
         al_head_ff   <= al_head_in;
         al_tail_ff   <= al_tail_in;
         al_used_ff   <= al_used_in;
         gmask_ff     <= gmask_in;
         for (int i = 0; i < BRANCHES; i++) begin
            ckmask_ff[i] <= ckmask_in[i];
            ckhead_ff[i] <= ckhead_in[i];
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff <= act_in; lreg_ff <= lreg_in; preg_ff <= preg_in;
      dvalid_ff <= dvalid_in; kind_ff <= kind_in; pc_ff <= pc_in;
      alx_ff <= alx_in; bid_ff <= bid_in; corr_ff <= corr_in;
      res_phys_ff <= res_phys_in; res_bid_ff <= res_bid_in; res_alx_ff <= res_alx_in;
      res_hv_ff <= res_hv_in; res_flags_ff <= res_flags_in; res_pc_ff <= res_pc_in;
      res_err_ff <= res_err_in;
      rsp_phys_ff <= rsp_phys_in; rsp_bid_ff <= rsp_bid_in; rsp_alx_ff <= rsp_alx_in;
      rsp_hv_ff <= rsp_hv_in; rsp_flags_ff <= rsp_flags_in; rsp_pc_ff <= rsp_pc_in;
      rsp_free_ff <= rsp_free_in; rsp_used_ff <= rsp_used_in;
      rsp_mask_ff <= rsp_mask_in; rsp_err_ff <= rsp_err_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_phys_out       = rsp_phys_ff;
   assign rsp_br_tag_out     = rsp_bid_ff;
   assign rsp_alist_slot_out = rsp_alx_ff;
   assign rsp_head_valid     = rsp_hv_ff;
   assign rsp_head_flags     = rsp_flags_ff;
   assign rsp_head_pc        = rsp_pc_ff;
   assign rsp_free_count     = rsp_free_ff;
   assign rsp_active_count   = rsp_used_ff;
   assign rsp_branch_mask    = rsp_mask_ff;
   assign rsp_error          = rsp_err_ff;

endmodule

`default_nettype wire
